// ----- hdl/cdsd_pkg.sv -----
// Shared types, constants and calendar tables for the civil date / serial day converter.
// Used by cdsd_to_serial, cdsd_from_serial and the top level; depends on nothing.
`default_nettype none

package cdsd_pkg;

    typedef enum logic [2:0] {
        ST_OK,
        ST_YEAR,
        ST_MONTH,
        ST_DAY,
        ST_HOUR,
        ST_MINUTE,
        ST_SECOND,
        ST_MSEC
    } status_t;

    localparam int DAYS_PER_ERA  = 146097;
    localparam int MS_PER_HOUR   = 3600000;
    localparam int MS_PER_MINUTE = 60000;
    localparam int MS_PER_SECOND = 1000;

    // Reciprocals for division by constants: q = (x * M) >> S, exact for the input widths used.
    localparam int          REC25_S    = 21;
    localparam logic [17:0] REC25_M    = 18'(((64'd1 << REC25_S) + 64'd24) / 64'd25);
    localparam int          REC_ERA_S  = 45;
    localparam logic [28:0] REC_ERA_M  = 29'(((64'd1 << REC_ERA_S) + 64'd146096) / 64'd146097);
    localparam int          REC1460_S  = 29;
    localparam logic [19:0] REC1460_M  = 20'(((64'd1 << REC1460_S) + 64'd1459) / 64'd1460);
    localparam int          REC365_S   = 27;
    localparam logic [19:0] REC365_M   = 20'(((64'd1 << REC365_S) + 64'd364) / 64'd365);

    // First day of each month within a year that starts on March 1.
    function automatic logic [8:0] month_start(input logic [3:0] mp);
        logic [8:0] r;
        unique case (mp)
            4'd0:    r = 9'd0;
            4'd1:    r = 9'd31;
            4'd2:    r = 9'd61;
            4'd3:    r = 9'd92;
            4'd4:    r = 9'd122;
            4'd5:    r = 9'd153;
            4'd6:    r = 9'd184;
            4'd7:    r = 9'd214;
            4'd8:    r = 9'd245;
            4'd9:    r = 9'd275;
            4'd10:   r = 9'd306;
            4'd11:   r = 9'd337;
            default: r = 9'd0;
        endcase
        return r;
    endfunction

    // Longest length of a civil month; February is given its leap length.
    function automatic logic [4:0] month_len(input logic [3:0] m);
        logic [4:0] r;
        unique case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: r = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                   r = 5'd30;
            4'd2:                                       r = 5'd29;
            default:                                    r = 5'd0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/cdsd_to_serial.sv -----
// Civil date and time check and conversion to serial day and milliseconds of day.
// Five register stages; depends on cdsd_pkg.
`default_nettype none

module cdsd_to_serial #(
    parameter int MAX_YEAR = 100000
) (
    input  wire logic              clk,
    input  wire logic [16:0]       year,
    input  wire logic [3:0]        month,
    input  wire logic [4:0]        day,
    input  wire logic [4:0]        hour,
    input  wire logic [5:0]        minute,
    input  wire logic [5:0]        second,
    input  wire logic [9:0]        millisecond,
    output logic [26:0]            serial,
    output logic [26:0]            ms,
    output cdsd_pkg::status_t      status
);

    localparam int DLY = 4;

    logic              month_low;
    logic [17:0]       ysh;
    logic [3:0]        mp;
    logic [8:0]        doy;
    logic [33:0]       qy_prod;
    logic [33:0]       qs_prod;
    cdsd_pkg::status_t st1;
    logic              feb29;

    logic [16:0]       year_reg;
    logic [17:0]       ysh_reg;
    logic [8:0]        doy_reg;
    logic [10:0]       qy_reg;
    logic [10:0]       qs_reg;
    cdsd_pkg::status_t st1_reg;
    logic              feb29_reg;
    logic [26:0]       hp_reg;
    logic [26:0]       mip_reg;
    logic [26:0]       sp_reg;
    logic [9:0]        msec_reg;

    logic [14:0]       rem25;
    logic              leap;
    cdsd_pkg::status_t st2;
    logic [26:0]       serial2;
    logic [26:0]       ms2;

    logic [26:0]       serial_reg [DLY];
    logic [26:0]       ms_reg [DLY];
    cdsd_pkg::status_t st_reg [DLY];

    always_comb
    begin
        month_low = (month <= 4'd2);
        ysh       = 18'(year) + 18'd400 - {17'b0, month_low};
        mp        = month_low ? (month + 4'd9) : (month - 4'd3);
        doy       = cdsd_pkg::month_start(mp) + 9'(day) - 9'd1;
        qy_prod   = 34'(year[16:2]) * 34'(cdsd_pkg::REC25_M);
        qs_prod   = 34'(ysh[17:2]) * 34'(cdsd_pkg::REC25_M);
        feb29     = (month == 4'd2) && (day == 5'd29);
        priority if ({15'b0, year} > 32'(MAX_YEAR))
            st1 = cdsd_pkg::ST_YEAR;
        else if (month == 4'd0 || month > 4'd12)
            st1 = cdsd_pkg::ST_MONTH;
        else if (day == 5'd0 || day > cdsd_pkg::month_len(month))
            st1 = cdsd_pkg::ST_DAY;
        else if (hour > 5'd23)
            st1 = cdsd_pkg::ST_HOUR;
        else if (minute > 6'd59)
            st1 = cdsd_pkg::ST_MINUTE;
        else if (second > 6'd59)
            st1 = cdsd_pkg::ST_SECOND;
        else if (millisecond > 10'd999)
            st1 = cdsd_pkg::ST_MSEC;
        else
            st1 = cdsd_pkg::ST_OK;
    end

    always_ff @(posedge clk)
    begin
        year_reg  <= year;
        ysh_reg   <= ysh;
        doy_reg   <= doy;
        qy_reg    <= qy_prod[cdsd_pkg::REC25_S +: 11];
        qs_reg    <= qs_prod[cdsd_pkg::REC25_S +: 11];
        st1_reg   <= st1;
        feb29_reg <= feb29;
        hp_reg    <= 27'(hour) * 27'(cdsd_pkg::MS_PER_HOUR);
        mip_reg   <= 27'(minute) * 27'(cdsd_pkg::MS_PER_MINUTE);
        sp_reg    <= 27'(second) * 27'(cdsd_pkg::MS_PER_SECOND);
        msec_reg  <= millisecond;
    end

    always_comb
    begin
        rem25   = year_reg[16:2] - 15'(15'(qy_reg) * 15'd25);
        leap    = (year_reg[1:0] == 2'd0) && (rem25 != 15'd0 || year_reg[3:0] == 4'd0);
        st2     = (feb29_reg && !leap && st1_reg != cdsd_pkg::ST_YEAR) ?
                  cdsd_pkg::ST_DAY : st1_reg;
        serial2 = 27'(ysh_reg) * 27'd365 + 27'(ysh_reg[17:2]) - 27'(qs_reg)
                  + 27'(qs_reg[10:2]) + 27'(doy_reg) - 27'(cdsd_pkg::DAYS_PER_ERA);
        ms2     = hp_reg + mip_reg + sp_reg + 27'(msec_reg);
    end

    always_ff @(posedge clk)
    begin
        serial_reg[0] <= (st2 == cdsd_pkg::ST_OK) ? serial2 : 27'd0;
        ms_reg[0]     <= (st2 == cdsd_pkg::ST_OK) ? ms2 : 27'd0;
        st_reg[0]     <= st2;
        for (int i = 1; i < DLY; i++)
        begin
            serial_reg[i] <= serial_reg[i-1];
            ms_reg[i]     <= ms_reg[i-1];
            st_reg[i]     <= st_reg[i-1];
        end
    end

    assign serial = serial_reg[DLY-1];
    assign ms     = ms_reg[DLY-1];
    assign status = st_reg[DLY-1];

endmodule

`default_nettype wire

// ----- hdl/cdsd_from_serial.sv -----
// Serial day to civil year, month and day over 400-year eras, with range check.
// Five register stages and a final month search; depends on cdsd_pkg.
`default_nettype none

module cdsd_from_serial #(
    parameter int MAX_YEAR = 100000
) (
    input  wire logic                clk,
    input  wire logic signed [26:0]  serial_in,
    output logic [16:0]              year,
    output logic [3:0]               month,
    output logic [4:0]               day,
    output cdsd_pkg::status_t        status
);

    localparam logic signed [31:0] TOP_SERIAL = 32'(
        365 * longint'(MAX_YEAR) + MAX_YEAR / 4 - MAX_YEAR / 100 + MAX_YEAR / 400 + 305);

    logic signed [31:0] zs;
    logic               bad;
    logic [26:0]        z_sh;
    logic [55:0]        era_prod;

    logic [26:0]        z_reg;
    logic [9:0]         era1_reg;
    logic               bad1_reg;

    logic [26:0]        doe_full;
    logic [17:0]        doe2_reg;
    logic [9:0]         era2_reg;
    logic               bad2_reg;

    logic [37:0]        a_prod;
    logic [2:0]         cent;
    logic               last_day;
    logic [17:0]        num;
    logic [17:0]        num3_reg;
    logic [17:0]        doe3_reg;
    logic [9:0]         era3_reg;
    logic               bad3_reg;

    logic [37:0]        y_prod;
    logic [8:0]         yoe4_reg;
    logic [17:0]        doe4_reg;
    logic [9:0]         era4_reg;
    logic               bad4_reg;

    logic [1:0]         c100;
    logic [17:0]        doy_full;
    logic [8:0]         doy5_reg;
    logic [8:0]         yoe5_reg;
    logic [9:0]         era5_reg;
    logic               bad5_reg;

    logic [3:0]         mp;
    logic [3:0]         m_calc;

    always_comb
    begin
        zs       = 32'(serial_in);
        bad      = (zs < -32'sd60) || (zs > TOP_SERIAL);
        z_sh     = 27'(serial_in) + 27'(cdsd_pkg::DAYS_PER_ERA);
        era_prod = 56'(z_sh) * 56'(cdsd_pkg::REC_ERA_M);
    end

    always_ff @(posedge clk)
    begin
        z_reg    <= z_sh;
        era1_reg <= era_prod[cdsd_pkg::REC_ERA_S +: 10];
        bad1_reg <= bad;
    end

    assign doe_full = z_reg - 27'(27'(era1_reg) * 27'(cdsd_pkg::DAYS_PER_ERA));

    always_ff @(posedge clk)
    begin
        doe2_reg <= doe_full[17:0];
        era2_reg <= era1_reg;
        bad2_reg <= bad1_reg;
    end

    always_comb
    begin
        a_prod   = 38'(doe2_reg) * 38'(cdsd_pkg::REC1460_M);
        cent     = 3'(doe2_reg >= 18'd36524) + 3'(doe2_reg >= 18'd73048)
                   + 3'(doe2_reg >= 18'd109572) + 3'(doe2_reg >= 18'd146096);
        last_day = (doe2_reg == 18'd146096);
        num      = doe2_reg - 18'(a_prod[cdsd_pkg::REC1460_S +: 7]) + 18'(cent)
                   - 18'(last_day);
    end

    always_ff @(posedge clk)
    begin
        num3_reg <= num;
        doe3_reg <= doe2_reg;
        era3_reg <= era2_reg;
        bad3_reg <= bad2_reg;
    end

    assign y_prod = 38'(num3_reg) * 38'(cdsd_pkg::REC365_M);

    always_ff @(posedge clk)
    begin
        yoe4_reg <= y_prod[cdsd_pkg::REC365_S +: 9];
        doe4_reg <= doe3_reg;
        era4_reg <= era3_reg;
        bad4_reg <= bad3_reg;
    end

    always_comb
    begin
        c100     = 2'(yoe4_reg >= 9'd100) + 2'(yoe4_reg >= 9'd200) + 2'(yoe4_reg >= 9'd300);
        doy_full = doe4_reg - (18'(yoe4_reg) * 18'd365 + 18'(yoe4_reg[8:2]) - 18'(c100));
    end

    always_ff @(posedge clk)
    begin
        doy5_reg <= doy_full[8:0];
        yoe5_reg <= yoe4_reg;
        era5_reg <= era4_reg;
        bad5_reg <= bad4_reg;
    end

    always_comb
    begin
        mp = 4'd0;
        for (int k = 1; k < 12; k++)
        begin
            if (doy5_reg >= cdsd_pkg::month_start(4'(k)))
                mp = 4'(k);
        end
        m_calc = (mp < 4'd10) ? (mp + 4'd3) : (mp - 4'd9);
        if (bad5_reg)
        begin
            year   = 17'd0;
            month  = 4'd0;
            day    = 5'd0;
            status = cdsd_pkg::ST_YEAR;
        end
        else
        begin
            year   = 17'(yoe5_reg) + 17'(era5_reg) * 17'd400 - 17'd400
                     + 17'(m_calc <= 4'd2);
            month  = m_calc;
            day    = 5'(doy5_reg - cdsd_pkg::month_start(mp) + 9'd1);
            status = cdsd_pkg::ST_OK;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/civil_date_serial_day_converter.sv -----
// Top level of the two-way Gregorian date converter: request capture, valid pipeline,
// result register. Depends on cdsd_pkg, cdsd_to_serial and cdsd_from_serial.
//
//  Channel   Handshake        Fields
//  request   start / busy     func, year, month, day, hour, minute, second,
//                             millisecond, serial_in
//  result    done (strobe)    serial_out, ms_of_day, year_out, month_out,
//                             day_out, status
//
// A request is taken in any cycle where start is high; busy stays low.
// Each result is loaded into the result register and shown for one cycle, with done high.
// Both conversion paths are five-stage pipelines run in parallel; the result register
// picks one by func. Reset clears only the valid bits and done.
`default_nettype none

module civil_date_serial_day_converter #(
    parameter int MAX_YEAR = 100000
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire logic                func,
    input  wire logic [16:0]         year,
    input  wire logic [3:0]          month,
    input  wire logic [4:0]          day,
    input  wire logic [4:0]          hour,
    input  wire logic [5:0]          minute,
    input  wire logic [5:0]          second,
    input  wire logic [9:0]          millisecond,
    input  wire logic signed [26:0]  serial_in,
    output logic                     done,
    output logic signed [26:0]       serial_out,
    output logic [26:0]              ms_of_day,
    output logic [16:0]              year_out,
    output logic [3:0]               month_out,
    output logic [4:0]               day_out,
    output logic [2:0]               status
);

    localparam int LAT = 5;

    logic [LAT-1:0]    vld_reg;
    logic [LAT-1:0]    vld_next;
    logic [LAT-1:0]    func_reg;
    logic              done_reg;

    logic [26:0]       civ_serial;
    logic [26:0]       civ_ms;
    cdsd_pkg::status_t civ_status;
    logic [16:0]       ser_year;
    logic [3:0]        ser_month;
    logic [4:0]        ser_day;
    cdsd_pkg::status_t ser_status;

    logic [26:0]       serial_out_reg;
    logic [26:0]       ms_reg;
    logic [16:0]       year_reg;
    logic [3:0]        month_reg;
    logic [4:0]        day_reg;
    logic [2:0]        status_reg;

    cdsd_to_serial #(
        .MAX_YEAR (MAX_YEAR)
    ) u_to_serial (
        .clk         (clk),
        .year        (year),
        .month       (month),
        .day         (day),
        .hour        (hour),
        .minute      (minute),
        .second      (second),
        .millisecond (millisecond),
        .serial      (civ_serial),
        .ms          (civ_ms),
        .status      (civ_status)
    );

    cdsd_from_serial #(
        .MAX_YEAR (MAX_YEAR)
    ) u_from_serial (
        .clk       (clk),
        .serial_in (serial_in),
        .year      (ser_year),
        .month     (ser_month),
        .day       (ser_day),
        .status    (ser_status)
    );

    assign vld_next = {vld_reg[LAT-2:0], start};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            vld_reg  <= vld_next;
            done_reg <= vld_reg[LAT-1];
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg <= {func_reg[LAT-2:0], func};
        if (vld_reg[LAT-1])
        begin
            if (func_reg[LAT-1])
            begin
                serial_out_reg <= 27'd0;
                ms_reg         <= 27'd0;
                year_reg       <= ser_year;
                month_reg      <= ser_month;
                day_reg        <= ser_day;
                status_reg     <= ser_status;
            end
            else
            begin
                serial_out_reg <= civ_serial;
                ms_reg         <= civ_ms;
                year_reg       <= 17'd0;
                month_reg      <= 4'd0;
                day_reg        <= 5'd0;
                status_reg     <= civ_status;
            end
        end
    end

    assign busy       = 1'b0;
    assign done       = done_reg;
    assign serial_out = serial_out_reg;
    assign ms_of_day  = ms_reg;
    assign year_out   = year_reg;
    assign month_out  = month_reg;
    assign day_out    = day_reg;
    assign status     = status_reg;

endmodule

`default_nettype wire
